[src/fqs_pkg.sv]
// Shared types and constants for the FIFO queue with linear search.
// Used by fqs_mem, fqs_ctrl and fifo_queue_with_search.
package fqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_UNDER    = 3'd1,
        ST_OVER     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // one finished result handed from the controller to the output stage
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [POS_W-1:0] position;
    } res_t;

endpackage

[src/fqs_mem.sv]
// Entry store: one write port, one read port, registered read data.
// Depends on fqs_pkg for the value width.
module fqs_mem
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/fqs_ctrl.sv]
// Queue controller: head/tail/fill state, insert and remove, and the
// search sequencer that streams entries out of fqs_mem one per cycle.
// Depends on fqs_pkg.
module fqs_ctrl
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OP_W-1:0]           op,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      slot_busy,
    output res_t                      res,
    output logic                      wr_en,
    output logic [AW-1:0]             wr_addr,
    output logic signed [VALUE_W-1:0] wr_data,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    input  logic signed [VALUE_W-1:0] rd_data
);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    state_t                    state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             tail_reg, tail_next;
    logic [CW-1:0]             fill_reg, fill_next;
    logic [AW-1:0]             cmp_k_reg, cmp_k_next;
    logic [AW-1:0]             rd_addr_reg, rd_addr_next;
    logic signed [VALUE_W-1:0] key_reg;
    logic                      accept;
    logic [CW-1:0]             cmp_k_inc;
    logic [AW+POS_W-1:0]       k_ext;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !slot_busy;
    assign accept    = in_valid && in_ready;
    assign cmp_k_inc = CW'(cmp_k_reg) + CW'(1);
    assign k_ext     = {{POS_W{1'b0}}, cmp_k_reg};

    assign wr_addr = tail_reg;
    assign wr_data = value;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        cmp_k_next   = cmp_k_reg;
        rd_addr_next = rd_addr_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = rd_addr_reg;
        res.valid    = 1'b0;
        res.status   = ST_DONE;
        res.position = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res.valid = 1'b1;
                    case (op)
                        OP_INSERT:
                        begin
                            if (fill_reg == FULL_CNT)
                            begin
                                res.status = ST_OVER;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                tail_next = ring_next(tail_reg);
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (fill_reg == '0)
                            begin
                                res.status = ST_UNDER;
                            end
                            else
                            begin
                                fill_next = fill_reg - CW'(1);
                                if (fill_reg == CW'(1))
                                begin
                                    // queue drains: both indices go home
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else
                                begin
                                    head_next = ring_next(head_reg);
                                end
                            end
                        end
                        OP_FIND:
                        begin
                            if (fill_reg == '0)
                            begin
                                res.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                // result comes from the search walk
                                res.valid    = 1'b0;
                                rd_en        = 1'b1;
                                rd_addr      = head_reg;
                                rd_addr_next = ring_next(head_reg);
                                cmp_k_next   = '0;
                                state_next   = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            res.status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // rd_data holds entry number cmp_k_reg from the head
                if (rd_data == key_reg)
                begin
                    res.valid    = 1'b1;
                    res.status   = ST_FOUND;
                    res.position = k_ext[POS_W-1:0];
                    state_next   = S_IDLE;
                end
                else if (cmp_k_inc == fill_reg)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = rd_addr_reg;
                    rd_addr_next = ring_next(rd_addr_reg);
                    cmp_k_next   = cmp_k_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            cmp_k_reg   <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            cmp_k_reg   <= cmp_k_next;
            rd_addr_reg <= rd_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= value;
        end
    end

endmodule

[src/fifo_queue_with_search.sv]
// Top level of the FIFO queue with linear search: controller, entry store
// and a two-slot result buffer. Depends on fqs_pkg, fqs_mem, fqs_ctrl.
//
//   channel   signals                          transfer when
//   input     in_valid, in_ready, op, value    in_valid && in_ready
//   output    out_valid, out_ready, status,    out_valid && out_ready
//             position
//
// Insert, remove and unused op codes finish in the cycle they are taken.
// A find walks k entries from the head, k being 1..DEPTH, with one
// store read per cycle; a find on an empty queue finishes at once.
// Reset clears indices and fill count; the entry store is not cleared.
// A result waits in the output register while the next item is taken; the
// input stalls while a find walks, and when a second finished result waits.
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OP_W-1:0]           op,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic [POS_W-1:0]          position
);

    localparam int AW = $clog2(DEPTH);

    res_t                      res;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic signed [VALUE_W-1:0] rd_data;

    res_t out_reg, out_next;
    res_t pend_reg, pend_next;
    logic out_free;

    fqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .slot_busy (pend_reg.valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    fqs_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_reg.valid || out_ready;

    // pending slot is always older than a new result; a new result never
    // arrives while the pending slot is full
    always_comb
    begin
        out_next  = out_reg;
        pend_next = pend_reg;
        if (out_free)
        begin
            if (pend_reg.valid)
            begin
                out_next  = pend_reg;
                pend_next = res;
            end
            else
            begin
                out_next = res;
            end
        end
        else if (res.valid)
        begin
            pend_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            out_reg  <= out_next;
            pend_reg <= pend_next;
        end
    end

    assign out_valid = out_reg.valid;
    assign status    = out_reg.status;
    assign position  = out_reg.position;

endmodule

[tb/queue_search_check.sv]
`timescale 1ns / 100ps
// Checker for fifo_queue_with_search. It watches both channels and keeps its own copy of the queue.
// It predicts each result, compares it and counts mismatches. Depends on fqs_pkg.
module queue_search_check
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [OP_W-1:0]           op,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [STATUS_W-1:0]       status,
    input  logic [POS_W-1:0]          position,
    output int                        mismatch_count,
    output int                        awaited_count,
    output int                        checked_count,
    output int                        found_count,
    output int                        overflow_count,
    output int                        underflow_count
);

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] position;
    } outcome_t;

    logic [VALUE_W-1:0] held_values [DEPTH];
    int                 head_slot  = 0;
    int                 tail_slot  = 0;
    int                 fill_level = 0;
    outcome_t           awaited_outcomes [$];

    int mismatches = 0;
    int checked    = 0;
    int found_hits = 0;
    int overflows  = 0;
    int underflows = 0;

    function automatic int ring_step(input int slot);
        return (slot + 1 >= DEPTH) ? 0 : slot + 1;
    endfunction

    // applies one operation to the shadow queue and returns the outcome it should give
    function automatic outcome_t apply_op(input logic [OP_W-1:0] code,
                                          input logic [VALUE_W-1:0] data);
        outcome_t res;
        int       slot;
        res.status   = ST_DONE;
        res.position = '0;
        case (code)
            OP_INSERT:
            begin
                if (fill_level >= DEPTH)
                    res.status = ST_OVER;
                else
                begin
                    held_values[tail_slot] = data;
                    tail_slot = ring_step(tail_slot);
                    fill_level++;
                end
            end
            OP_REMOVE:
            begin
                if (fill_level == 0)
                    res.status = ST_UNDER;
                else
                begin
                    fill_level--;
                    // an emptied queue restarts at slot 0
                    if (fill_level == 0)
                    begin
                        head_slot = 0;
                        tail_slot = 0;
                    end
                    else
                        head_slot = ring_step(head_slot);
                end
            end
            OP_FIND:
            begin
                res.status = ST_NOTFOUND;
                slot = head_slot;
                for (int k = 0; k < fill_level; k++)
                begin
                    if (held_values[slot] == data)
                    begin
                        res.status   = ST_FOUND;
                        res.position = POS_W'(k);
                        break;
                    end
                    slot = ring_step(slot);
                end
            end
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 20)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            head_slot  = 0;
            tail_slot  = 0;
            fill_level = 0;
            awaited_outcomes.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                awaited_outcomes.push_back(apply_op(op, value));
            if (out_valid && out_ready)
            begin
                if (awaited_outcomes.size() == 0)
                    report_mismatch($sformatf("result status=%0d position=%0d with none awaited",
                                              status, position));
                else
                begin
                    want = awaited_outcomes.pop_front();
                    checked++;
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (position !== want.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  position, want.position));
                    case (want.status)
                        ST_FOUND: found_hits++;
                        ST_OVER:  overflows++;
                        ST_UNDER: underflows++;
                        default:  ;
                    endcase
                end
            end
        end
        mismatch_count  <= mismatches;
        awaited_count   <= awaited_outcomes.size();
        checked_count   <= checked;
        found_count     <= found_hits;
        overflow_count  <= overflows;
        underflow_count <= underflows;
    end

endmodule

[tb/tb_fifo_queue_with_search.sv]
`timescale 1ns / 100ps
// Testbench top for fifo_queue_with_search: clock, reset, paced stimulus and the verdict.
// Depends on fqs_pkg, the block's sources and queue_search_check.
module tb_fifo_queue_with_search;
    import fqs_pkg::*;

    localparam logic [OP_W-1:0]           OP_UNUSED    = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN      = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX      = 32'sh7FFF_FFFF;
    localparam int                        RANDOM_ITEMS = 700;
    localparam int                        DRAIN_CYCLES = 24;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [OP_W-1:0]           op        = '0;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          position;

    int mismatch_count;
    int awaited_count;
    int checked_count;
    int found_count;
    int overflow_count;
    int underflow_count;

    int                        sent_items  = 0;
    int                        burst_left  = 0;
    int                        ready_hold  = 0;
    logic signed [VALUE_W-1:0] value_pool [8];
    logic signed [VALUE_W-1:0] recent_inserts [16];
    int                        recent_fill = 0;
    int                        recent_wr   = 0;

    fifo_queue_with_search #(.DEPTH(DEPTH_DEF)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .position  (position)
    );

    queue_search_check #(.DEPTH(DEPTH_DEF)) u_queue_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .position        (position),
        .mismatch_count  (mismatch_count),
        .awaited_count   (awaited_count),
        .checked_count   (checked_count),
        .found_count     (found_count),
        .overflow_count  (overflow_count),
        .underflow_count (underflow_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: long ready stretches, short stalls and the odd long stall
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    out_ready  <= 1'b1;
                    ready_hold <= $urandom_range(0, 15);
                end
                6, 7, 8:
                begin
                    out_ready  <= 1'b0;
                    ready_hold <= $urandom_range(0, 3);
                end
                default:
                begin
                    out_ready  <= 1'b0;
                    ready_hold <= $urandom_range(10, 24);
                end
            endcase
        end
    end

    function automatic logic signed [VALUE_W-1:0] fresh_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] choose_op(input traffic_mode_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_UNUSED;
        if (roll < 27)
            return OP_FIND;
        case (mode)
            MODE_FILL:  return (roll < 90) ? OP_INSERT : OP_REMOVE;
            MODE_DRAIN: return (roll < 85) ? OP_REMOVE : OP_INSERT;
            default:    return (roll < 64) ? OP_INSERT : OP_REMOVE;
        endcase
    endfunction

    // half of the finds target values inserted lately, so that deep positions get hit
    function automatic logic signed [VALUE_W-1:0] choose_value(input logic [OP_W-1:0] code);
        int roll;
        roll = $urandom_range(0, 99);
        if (code == OP_FIND)
        begin
            if (recent_fill > 0 && roll < 50)
                return recent_inserts[$urandom_range(0, recent_fill - 1)];
            if (roll < 75)
                return value_pool[$urandom_range(0, 7)];
        end
        else if (roll < 40)
            return value_pool[$urandom_range(0, 7)];
        return fresh_value();
    endfunction

    // one transfer on the input channel, followed by the sender's burst pacing
    task automatic push_item(input logic [OP_W-1:0] code,
                             input logic signed [VALUE_W-1:0] data);
        in_valid <= 1'b1;
        op       <= code;
        value    <= data;
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
        if (code == OP_INSERT)
        begin
            recent_inserts[recent_wr] = data;
            recent_wr = (recent_wr + 1) % 16;
            if (recent_fill < 16)
                recent_fill++;
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
        end
    endtask

    initial
    begin
        traffic_mode_t             mode;
        int                        phase_len;
        int                        random_sent;
        logic [OP_W-1:0]           code;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-queue cases, extremes, duplicates, unused code
        push_item(OP_REMOVE, 32'sd0);
        push_item(OP_FIND, 32'sd5);
        push_item(OP_UNUSED, VAL_MAX);
        push_item(OP_INSERT, VAL_MIN);
        push_item(OP_INSERT, VAL_MAX);
        push_item(OP_FIND, VAL_MAX);
        push_item(OP_REMOVE, VAL_MAX);
        push_item(OP_REMOVE, 32'sd0);       // empties from a nonzero head
        push_item(OP_REMOVE, 32'sd0);
        push_item(OP_FIND, VAL_MAX);
        push_item(OP_INSERT, 32'sd0);
        push_item(OP_INSERT, -32'sd1);
        push_item(OP_INSERT, VAL_MIN);
        push_item(OP_INSERT, -32'sd1);
        push_item(OP_FIND, -32'sd1);        // nearest of two matches
        push_item(OP_FIND, 32'sd0);
        push_item(OP_FIND, VAL_MIN);
        push_item(OP_FIND, 32'sh5555_AAAA);
        push_item(OP_REMOVE, 32'sh7FFF_0000);
        push_item(OP_FIND, -32'sd1);
        push_item(OP_UNUSED, VAL_MIN);

        // random phases: fill-heavy ones reach overflow, drain-heavy ones underflow
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            mode      = traffic_mode_t'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 80);
            if (phase_len > RANDOM_ITEMS - random_sent)
                phase_len = RANDOM_ITEMS - random_sent;
            for (int i = 0; i < 8; i++)
                value_pool[i] = fresh_value();
            repeat (phase_len)
            begin
                code = choose_op(mode);
                push_item(code, choose_value(code));
                random_sent++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input transfers, %0d results checked", sent_items, checked_count);
        $display("finds hit %0d, overflows %0d, underflows %0d",
                 found_count, overflow_count, underflow_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/fqs_pkg.sv
src/fqs_mem.sv
src/fqs_ctrl.sv
src/fifo_queue_with_search.sv
tb/queue_search_check.sv
tb/tb_fifo_queue_with_search.sv
